### hdl/gfd_pkg.sv
// gfd_pkg: shared types, constants and the cordic arctangent table
package gfd_pkg;

  typedef enum logic [1:0] {
    OP_FIX     = 2'd0,
    OP_RESTART = 2'd1,
    OP_FLUSHED = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_RECORDING     = 2'd0,
    CFG_MIN_INTERVAL  = 2'd1,
    CFG_DISTANCE_ONLY = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ZMUL,
    ST_ZRND,
    ST_CORD,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_CMP,
    ST_FIN
  } state_t;

  localparam int ANG_W    = 34;
  localparam int MUL_W    = 34;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int CXY_W    = 34;
  localparam int CZ_W     = 33;
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [ANG_W-1:0] FULL_TURN    = 34'sd7200000000;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd3600000000;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1800000000;
  localparam logic signed [MUL_W-1:0] HALF_UNIT_TO_RAD = 34'sd4024455254;
  localparam logic signed [CXY_W-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [CXY_W-1:0] ONE_Q30      = 34'sd1073741824;
  localparam logic [63:0] MIN_A_Q62 = 64'd113617;
  localparam logic [63:0] Z_ROUND   = 64'h0000_0000_8000_0000;

  function automatic logic [CZ_W-1:0] atan_q30(input logic [4:0] i);
    logic [CZ_W-1:0] v;
    case (i)
      5'd0:  v = 33'h03243F6A8;
      5'd1:  v = 33'h01DAC6705;
      5'd2:  v = 33'h00FADBAFC;
      5'd3:  v = 33'h007F56EA6;
      5'd4:  v = 33'h003FEAB76;
      5'd5:  v = 33'h001FFD55B;
      5'd6:  v = 33'h000FFFAAA;
      5'd7:  v = 33'h0007FFF55;
      5'd8:  v = 33'h0003FFFEA;
      5'd9:  v = 33'h0001FFFFD;
      5'd10: v = 33'h0000FFFFF;
      5'd11: v = 33'h00007FFFF;
      5'd12: v = 33'h00003FFFF;
      5'd13: v = 33'h00001FFFF;
      5'd14: v = 33'h00000FFFF;
      5'd15: v = 33'h000007FFF;
      5'd16: v = 33'h000003FFF;
      5'd17: v = 33'h000001FFF;
      5'd18: v = 33'h000000FFF;
      5'd19: v = 33'h0000007FF;
      5'd20: v = 33'h0000003FF;
      5'd21: v = 33'h0000001FF;
      5'd22: v = 33'h0000000FF;
      5'd23: v = 33'h00000007F;
      5'd24: v = 33'h00000003F;
      5'd25: v = 33'h00000001F;
      5'd26: v = 33'h00000000F;
      5'd27: v = 33'h000000007;
      5'd28: v = 33'h000000003;
      5'd29: v = 33'h000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/gfd_if.sv
// gfd_if: valid/ready channel interfaces for fix items and result items
interface gfd_fix_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [30:0] lat_e7;
  logic signed [31:0] lon_e7;
  logic [31:0]        fix_time_s;
  logic [31:0]        now_ms;
  modport source (output valid, opcode, lat_e7, lon_e7, fix_time_s, now_ms, input ready);
  modport sink   (input valid, opcode, lat_e7, lon_e7, fix_time_s, now_ms, output ready);
endinterface

interface gfd_res_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       flush_request;
  logic       buffer_full;
  logic [6:0] pending_points;
  modport source (output valid, accepted, flush_request, buffer_full, pending_points,
                  input ready);
  modport sink   (input valid, accepted, flush_request, buffer_full, pending_points,
                  output ready);
endinterface

### hdl/gfd_mul.sv
// gfd_mul: shared signed multiplier with registered product
module gfd_mul
  import gfd_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### hdl/gfd_cordic.sv
// gfd_cordic: one-step-per-cycle cordic rotation giving sin and cos in q4.30
module gfd_cordic
  import gfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CZ_W-1:0]  z0,
  output logic signed [CXY_W-1:0] x,
  output logic signed [CXY_W-1:0] y,
  output logic                    done
);

  logic                   busy;
  logic [4:0]             step;
  logic signed [CZ_W-1:0] z;
  logic signed [CXY_W-1:0] dx, dy;
  logic [CZ_W-1:0]         at;

  always_comb begin
    dx = y >>> step;
    dy = x >>> step;
    at = atan_q30(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_GAIN;
      y <= '0;
      z <= z0;
    end else if (busy) begin
      if (!z[CZ_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - $signed(at);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + $signed(at);
      end
    end
  end

endmodule

### hdl/gps_fix_decimation_filter_unit.sv
// gps_fix_decimation_filter_unit: top level, sequencer around shared cordic and multiplier
//
//  channel   dir  handshake     payload
//  fix_in    in   valid/ready   opcode, lat_e7, lon_e7, fix_time_s, now_ms
//  res_out   out  valid/ready   accepted, flush_request, buffer_full, pending_points
//  cfg       in   cfg_we        cfg_index, cfg_data
//
//  a fix offered after a kept fix, while recording is enabled, works four angles in
//  turn, each through prep, multiply, rounding and the cordic states, then the four
//  multiply states, the compare state and the result state
//  other items go straight to the result state; the single cordic unit, used once per angle, dominates the work
//  fix_in is not ready while an item is in work; the result waits in an output
//  register until taken, the next item may be accepted meanwhile
//  rst is synchronous and clears all track state and configuration
module gps_fix_decimation_filter_unit
  import gfd_pkg::*;
#(
  parameter int BUFFER_DEPTH    = 16,
  parameter int FLUSH_COUNT     = 6,
  parameter int FLUSH_PERIOD_MS = 5000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  gfd_fix_if.sink     fix_in,
  gfd_res_if.source   res_out
);

  state_t state, state_next;

  logic        recording_enabled;
  logic [19:0] min_interval_ms;
  logic        distance_only;

  logic               last_valid;
  logic signed [30:0] last_lat;
  logic signed [31:0] last_lon;
  logic [31:0]        last_fix_time;
  logic [31:0]        last_local_ms;
  logic [6:0]         pending_count;
  logic [31:0]        last_flush_ms;

  logic [1:0]         op;
  logic signed [30:0] lat;
  logic signed [31:0] lon;
  logic [31:0]        fix_t;
  logic [31:0]        now;

  logic [1:0]  idx;
  logic        neg_cos;
  logic        rneg;
  logic [ANG_W-1:0] mag_q;
  logic signed [31:0] s1, s2, cl1, cl2;
  logic [63:0] first;
  logic signed [MUL_W-1:0] p1;
  logic        too_close;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     cd_start;
  logic signed [CZ_W-1:0]   cd_z;
  logic signed [CXY_W-1:0]  cd_x, cd_y;
  logic                     cd_done;

  logic signed [ANG_W-1:0] ang, r0, r1, r2;
  logic                    fold;
  logic [ANG_W-1:0]        mag;
  logic [63:0]             zsum;
  logic signed [CXY_W-1:0] cx, cs, cc;
  logic signed [31:0]      s_cl, c_cl;
  logic signed [MUL_W-1:0] p_cur;
  logic signed [PROD_W-1:0] neg_second;
  logic [63:0]             a_val;

  logic        out_free;
  logic        intv_ok, ok, full, acc, flush;
  logic [31:0] dms;
  logic [6:0]  pend_next;
  logic [6:0]  pend_out;

  gfd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  gfd_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cd_start), .z0(cd_z),
    .x(cd_x), .y(cd_y), .done(cd_done)
  );

  assign fix_in.ready = (state == ST_IDLE);
  assign out_free     = !res_out.valid || res_out.ready;

  // angle select, turn reduction and quarter fold
  always_comb begin
    case (idx)
      2'd0:    ang = ANG_W'(lat) - ANG_W'(last_lat);
      2'd1:    ang = ANG_W'(lon) - ANG_W'(last_lon);
      2'd2:    ang = ANG_W'(last_lat) <<< 1;
      default: ang = ANG_W'(lat) <<< 1;
    endcase
    r0 = (ang >= HALF_TURN) ? ang - FULL_TURN : ang;
    r1 = (r0 < -HALF_TURN) ? r0 + FULL_TURN : r0;
    fold = 1'b0;
    r2 = r1;
    if (r1 > QUARTER_TURN) begin
      r2 = HALF_TURN - r1;
      fold = 1'b1;
    end else if (r1 < -QUARTER_TURN) begin
      r2 = -HALF_TURN - r1;
      fold = 1'b1;
    end
    mag = r2[ANG_W-1] ? ANG_W'(-r2) : ANG_W'(r2);
  end

  always_comb begin
    zsum = 64'(prod) + Z_ROUND;
    cd_z = rneg ? -CZ_W'(zsum[63:32]) : CZ_W'(zsum[63:32]);
    cd_start = (state == ST_ZRND);
  end

  always_comb begin
    cs = cd_y;
    cx = neg_cos ? -cd_x : cd_x;
    if (cs > ONE_Q30) cs = ONE_Q30;
    else if (cs < -ONE_Q30) cs = -ONE_Q30;
    cc = cx;
    if (cx > ONE_Q30) cc = ONE_Q30;
    else if (cx < -ONE_Q30) cc = -ONE_Q30;
    s_cl = 32'(cs);
    c_cl = 32'(cc);
  end

  always_comb begin
    p_cur = MUL_W'(prod >>> 29);
    neg_second = -prod;
    if (!prod[PROD_W-1]) begin
      a_val = first + 64'(prod);
    end else begin
      a_val = (first > 64'(neg_second)) ? first - 64'(neg_second) : 64'd0;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_ZMUL: begin
        mul_a = $signed(mag_q);
        mul_b = HALF_UNIT_TO_RAD;
      end
      ST_MUL1: begin
        mul_a = MUL_W'(s1);
        mul_b = MUL_W'(s1);
      end
      ST_MUL2: begin
        mul_a = MUL_W'(cl1);
        mul_b = MUL_W'(s2);
      end
      ST_MUL3: begin
        mul_a = MUL_W'(cl2);
        mul_b = MUL_W'(s2);
      end
      ST_MUL4: begin
        mul_a = p1;
        mul_b = p_cur;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // keep decision
  always_comb begin
    dms = 32'((fix_t - last_fix_time) * 32'd1000);
    intv_ok = 1'b1;
    if (!distance_only && min_interval_ms != 20'd0) begin
      if (fix_t != 32'd0 && last_fix_time != 32'd0) begin
        intv_ok = (dms >= 32'(min_interval_ms));
      end else if (last_local_ms != 32'd0) begin
        intv_ok = (32'(now - last_local_ms) >= 32'(min_interval_ms));
      end
    end
    ok = (op == OP_FIX) && recording_enabled && !(last_valid && too_close) && intv_ok;
    full = ok && (pending_count >= 7'(BUFFER_DEPTH));
    acc = ok && !full;
    pend_next = pending_count + 7'd1;
    flush = full || (acc && (pend_next >= 7'(FLUSH_COUNT) || last_flush_ms == 32'd0 ||
                             32'(now - last_flush_ms) >= 32'(FLUSH_PERIOD_MS)));
    case (op)
      OP_RESTART: pend_out = '0;
      OP_FLUSHED: pend_out = '0;
      OP_FIX:     pend_out = acc ? pend_next : pending_count;
      default:    pend_out = pending_count;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (fix_in.valid) begin
          if (fix_in.opcode == OP_FIX && recording_enabled && last_valid)
            state_next = ST_PREP;
          else
            state_next = ST_FIN;
        end
      end
      ST_PREP: state_next = ST_ZMUL;
      ST_ZMUL: state_next = ST_ZRND;
      ST_ZRND: state_next = ST_CORD;
      ST_CORD: begin
        if (cd_done) state_next = (idx == 2'd3) ? ST_MUL1 : ST_PREP;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_MUL4;
      ST_MUL4: state_next = ST_CMP;
      ST_CMP:  state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recording_enabled <= 1'b0;
      min_interval_ms   <= '0;
      distance_only     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RECORDING:     recording_enabled <= cfg_data[0];
        CFG_MIN_INTERVAL:  min_interval_ms   <= cfg_data;
        CFG_DISTANCE_ONLY: distance_only     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && fix_in.valid) begin
      op    <= fix_in.opcode;
      lat   <= fix_in.lat_e7;
      lon   <= fix_in.lon_e7;
      fix_t <= fix_in.fix_time_s;
      now   <= fix_in.now_ms;
      idx   <= 2'd0;
      too_close <= 1'b0;
    end
    if (state == ST_PREP) begin
      neg_cos <= fold;
      rneg    <= r2[ANG_W-1];
      mag_q   <= mag;
    end
    if (state == ST_CORD && cd_done) begin
      case (idx)
        2'd0:    s1  <= s_cl;
        2'd1:    s2  <= s_cl;
        2'd2:    cl1 <= c_cl;
        default: cl2 <= c_cl;
      endcase
      idx <= idx + 2'd1;
    end
    if (state == ST_MUL2) first <= {prod[61:0], 2'b00};
    if (state == ST_MUL3) p1 <= p_cur;
    if (state == ST_CMP) too_close <= (a_val < MIN_A_Q62);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
      last_valid    <= 1'b0;
      last_lat      <= '0;
      last_lon      <= '0;
      last_fix_time <= '0;
      last_local_ms <= '0;
      pending_count <= '0;
      last_flush_ms <= '0;
    end else begin
      if (state == ST_FIN && out_free) begin
        res_out.valid          <= 1'b1;
        res_out.accepted       <= acc;
        res_out.flush_request  <= flush;
        res_out.buffer_full    <= full;
        res_out.pending_points <= pend_out;
        pending_count          <= pend_out;
        case (op)
          OP_RESTART: begin
            last_valid    <= 1'b0;
            last_fix_time <= '0;
            last_local_ms <= '0;
            last_flush_ms <= now;
          end
          OP_FLUSHED: begin
            last_flush_ms <= now;
          end
          OP_FIX: begin
            if (acc) begin
              last_valid    <= 1'b1;
              last_lat      <= lat;
              last_lon      <= lon;
              last_fix_time <= fix_t;
              last_local_ms <= now;
            end
          end
          default: ;
        endcase
      end else if (res_out.ready) begin
        res_out.valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/gfd_chk.sv
// gfd_chk: port-level assertions for the fix filter, bound to the top level
module gfd_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       accepted,
  input logic       flush_request,
  input logic       buffer_full,
  input logic [6:0] pending_points
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(accepted && buffer_full))
    else $error("item both kept and refused as full");

  a_full_flush: assert property (@(posedge clk) disable iff (rst)
    res_valid && buffer_full |-> flush_request)
    else $error("full without flush request");

  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending_points <= 7'd64)
    else $error("pending count out of range");

endmodule

bind gps_fix_decimation_filter_unit gfd_chk u_gfd_chk (
  .clk(clk), .rst(rst),
  .in_valid(fix_in.valid), .in_ready(fix_in.ready),
  .res_valid(res_out.valid), .res_ready(res_out.ready),
  .accepted(res_out.accepted), .flush_request(res_out.flush_request),
  .buffer_full(res_out.buffer_full), .pending_points(res_out.pending_points)
);
